// ===== src/twsched_pkg.sv =====
// Shared definitions for the timing wheel timer scheduler.
// Holds request field widths, request mode codes and parameter defaults.
// No dependencies.
package twsched_pkg;

  // Field widths of the request and result channels.
  localparam int MODE_W   = 2;
  localparam int ID_W     = 4;
  localparam int PERIOD_W = 16;

  // Defaults for the top-level parameters.
  localparam int DEFAULT_SLOTS  = 10;
  localparam int DEFAULT_TIMERS = 16;

  // Request mode codes.
  localparam logic [MODE_W-1:0] MODE_TICK   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ADD    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DELETE = 2'd2;

endpackage

// ===== src/timing_wheel_timer_scheduler_core.sv =====
// Timing wheel timer scheduler: hashed wheel of periodic timers.
// Depends on twsched_pkg for field widths, mode codes and defaults.
// A delete completes on acceptance; an add steps through accept, reciprocal multiply, remainder, write.
// A tick reads and checks each timer entry in turn, then ends the scan and flushes, and each
// timer that fires is re-armed via push, multiply, remainder and write; output stalls lengthen the tick.
// Synchronous reset disarms every timer and zeroes the current slot, not the tables.
module timing_wheel_timer_scheduler_core #(
  parameter int SLOTS  = twsched_pkg::DEFAULT_SLOTS,
  parameter int TIMERS = twsched_pkg::DEFAULT_TIMERS
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [twsched_pkg::MODE_W-1:0]   mode,
  input  logic [twsched_pkg::ID_W-1:0]     timer_id,
  input  logic [twsched_pkg::PERIOD_W-1:0] period,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [twsched_pkg::ID_W-1:0]     fired_id,
  output logic                             last
);
  import twsched_pkg::*;

  localparam int SW        = $clog2(SLOTS);
  localparam int IDX_W     = (TIMERS > 1) ? $clog2(TIMERS) : 1;
  localparam int CNT_W     = $clog2(TIMERS + 1);
  localparam int RECIP_SH  = PERIOD_W + SW;
  localparam int PROD_W    = 2 * PERIOD_W + 1;

  localparam logic [SW:0]          SLOTS_V   = (SW + 1)'(SLOTS);
  localparam logic [SW-1:0]        LAST_SLOT = SW'(SLOTS - 1);
  localparam logic [CNT_W-1:0]     TIMERS_V  = CNT_W'(TIMERS);
  // Rounded-up reciprocal of the slot count, exact for every period value.
  localparam logic [PERIOD_W:0]    RECIP     =
    (PERIOD_W + 1)'(((1 << RECIP_SH) + SLOTS - 1) / SLOTS);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_PUSH,
    ST_DIV,
    ST_REM,
    ST_WRITE,
    ST_FLUSH
  } state_t;

  state_t                 state;
  logic [SW-1:0]          cur_slot;
  logic [TIMERS-1:0]      armed;
  logic [CNT_W-1:0]       scan_cnt;
  logic [IDX_W-1:0]       scan_idx;
  logic                   tick_mode;
  logic [IDX_W-1:0]       tgt;
  logic [PERIOD_W-1:0]    per_reg;
  logic [PERIOD_W-1:0]    quo;
  logic [SW:0]            rem;
  logic [PROD_W-1:0]      prod;
  logic                   have_pend;
  logic [ID_W-1:0]        pend_id;

  // Timer tables, one entry per timer.
  logic [PERIOD_W-1:0]    period_mem [TIMERS];
  logic [SW-1:0]          slot_mem   [TIMERS];
  logic [PERIOD_W-1:0]    rounds_mem [TIMERS];
  logic [PERIOD_W-1:0]    rd_period;
  logic [SW-1:0]          rd_slot;
  logic [PERIOD_W-1:0]    rd_rounds;

  logic                   id_ok;
  logic [IDX_W-1:0]       id_idx;
  logic [PERIOD_W-1:0]    clamped;
  logic                   out_free;
  logic                   res_load;
  logic                   hit;
  logic [PERIOD_W-1:0]    div_q;
  logic [SW:0]            div_r;
  logic [SW:0]            slot_sum;
  logic [SW-1:0]          slot_new;
  logic                   rd_en;
  logic                   ent_we;
  logic                   dec_we;

  // Request decode and handshake.
  assign in_stall = (state != ST_IDLE);
  assign out_free = !out_valid || !out_stall;
  assign res_load = have_pend && out_free && ((state == ST_PUSH) || (state == ST_FLUSH));
  assign id_ok    = ({{(32 - ID_W){1'b0}}, timer_id} < 32'(TIMERS));
  assign id_idx   = IDX_W'(timer_id);
  assign clamped  = (period == '0) ? PERIOD_W'(1) : period;
  assign scan_idx = scan_cnt[IDX_W-1:0];

  // Scan compare against the entry read in the previous cycle.
  assign hit = armed[scan_idx] && (rd_slot == cur_slot);

  // Quotient by the slot count from the reciprocal product, and the
  // remainder from the low bits of the dividend.
  assign div_q = PERIOD_W'(prod[PROD_W-1:RECIP_SH]);
  assign div_r = quo[SW:0] - div_q[SW:0] * SLOTS_V;

  // New slot is current slot plus one plus the remainder, reduced once.
  assign slot_sum = {1'b0, cur_slot} + rem + (SW + 1)'(1);
  assign slot_new = (slot_sum >= SLOTS_V) ? SW'(slot_sum - SLOTS_V) : slot_sum[SW-1:0];

  // Table port controls.
  assign rd_en  = (state == ST_SCAN_RD) && (scan_cnt != TIMERS_V);
  assign ent_we = (state == ST_WRITE);
  assign dec_we = (state == ST_SCAN_CHK) && hit && (rd_rounds != '0);

  // Period and slot tables: written on arming, read during the scan.
  always_ff @(posedge clk) begin
    if (ent_we) begin
      period_mem[tgt] <= per_reg;
      slot_mem[tgt]   <= slot_new;
    end
    if (rd_en) begin
      rd_period <= period_mem[scan_idx];
      rd_slot   <= slot_mem[scan_idx];
    end
  end

  // Rounds table: written on arming or when a visited timer loses a round.
  always_ff @(posedge clk) begin
    if (ent_we) begin
      rounds_mem[tgt] <= quo;
    end else if (dec_we) begin
      rounds_mem[scan_idx] <= rd_rounds - PERIOD_W'(1);
    end
    if (rd_en) begin
      rd_rounds <= rounds_mem[scan_idx];
    end
  end

  // Sequencer, armed flags and the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cur_slot  <= '0;
      armed     <= '0;
      scan_cnt  <= '0;
      tick_mode <= 1'b0;
      have_pend <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (res_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            case (mode)
              MODE_TICK: begin
                cur_slot  <= (cur_slot == LAST_SLOT) ? '0 : cur_slot + SW'(1);
                scan_cnt  <= '0;
                tick_mode <= 1'b1;
                state     <= ST_SCAN_RD;
              end
              MODE_ADD: begin
                if (id_ok) begin
                  tgt       <= id_idx;
                  per_reg   <= clamped;
                  quo       <= clamped - PERIOD_W'(1);
                  tick_mode <= 1'b0;
                  state     <= ST_DIV;
                end
              end
              MODE_DELETE: begin
                if (id_ok) begin
                  armed[id_idx] <= 1'b0;
                end
              end
              default: ;
            endcase
          end
        end
        ST_SCAN_RD: begin
          state <= (scan_cnt == TIMERS_V) ? ST_FLUSH : ST_SCAN_CHK;
        end
        ST_SCAN_CHK: begin
          if (hit && (rd_rounds == '0)) begin
            state <= ST_PUSH;
          end else begin
            scan_cnt <= scan_cnt + CNT_W'(1);
            state    <= ST_SCAN_RD;
          end
        end
        // Hand the previous firing to the output, hold this one back so
        // that the final one of the tick can be marked.
        ST_PUSH: begin
          if (!have_pend || out_free) begin
            if (have_pend) begin
              fired_id  <= pend_id;
              last      <= 1'b0;
            end
            pend_id   <= ID_W'(scan_cnt);
            have_pend <= 1'b1;
            tgt       <= scan_idx;
            per_reg   <= rd_period;
            quo       <= rd_period - PERIOD_W'(1);
            state     <= ST_DIV;
          end
        end
        // Multiply the dividend by the reciprocal of the slot count.
        ST_DIV: begin
          prod  <= PROD_W'(quo) * PROD_W'(RECIP);
          state <= ST_REM;
        end
        // Keep the quotient as the round count and the remainder for the slot.
        ST_REM: begin
          quo   <= div_q;
          rem   <= div_r;
          state <= ST_WRITE;
        end
        ST_WRITE: begin
          armed[tgt] <= 1'b1;
          if (tick_mode) begin
            scan_cnt <= scan_cnt + CNT_W'(1);
            state    <= ST_SCAN_RD;
          end else begin
            state <= ST_IDLE;
          end
        end
        ST_FLUSH: begin
          if (!have_pend) begin
            state <= ST_IDLE;
          end else if (out_free) begin
            fired_id  <= pend_id;
            last      <= 1'b1;
            have_pend <= 1'b0;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // The scan never runs past the last timer entry.
  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    scan_cnt <= TIMERS_V)
    else $error("scan counter beyond timer count");

  // The remainder used for the new slot stays below the slot count.
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    state == ST_WRITE |-> rem < SLOTS_V)
    else $error("divider remainder out of range");

  // Every held-back firing is flushed before the next request.
  a_idle_no_pend: assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE |-> !have_pend)
    else $error("pending firing left over at idle");

  // A tick request starts a scan from the first entry.
  a_tick_scan: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && mode == MODE_TICK) |=>
      (state == ST_SCAN_RD && scan_cnt == '0))
    else $error("tick request did not start a scan");

  // A result only appears from the push or flush step.
  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == ST_PUSH || $past(state) == ST_FLUSH))
    else $error("result raised outside push or flush");

endmodule

// ===== verif/testbench.sv =====
// Testbench for timing_wheel_timer_scheduler_core: directed, random and backpressure tests.
// Results are checked in order against a predictor of the timer wheel kept in this file.
// Depends on twsched_pkg and the scheduler core in src.
`timescale 1ns / 100ps

module testbench;
  import twsched_pkg::*;

  localparam int SLOTS         = DEFAULT_SLOTS;
  localparam int TIMERS        = DEFAULT_TIMERS;
  localparam int MAX_FIRED     = 16;
  localparam int STALL_LIMIT   = 20000;
  localparam int DRAIN_CYCLES  = 400;
  localparam int HOLDOFF_LEN   = 1500;
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

  typedef struct packed {
    logic [ID_W-1:0] id;
    logic            last;
  } fired_t;

  logic                clk;
  logic                rst;
  logic                in_valid;
  logic                in_stall;
  logic [MODE_W-1:0]   mode;
  logic [ID_W-1:0]     timer_id;
  logic [PERIOD_W-1:0] period;
  logic                out_valid;
  logic                out_stall;
  logic [ID_W-1:0]     fired_id;
  logic                last;

  // Predicted wheel state.
  logic                armed_m  [TIMERS];
  logic [PERIOD_W-1:0] period_m [TIMERS];
  logic [3:0]          slot_m   [TIMERS];
  logic [PERIOD_W-1:0] rounds_m [TIMERS];
  logic [3:0]          cur_slot_m;

  fired_t fired_expect_q[$];

  int send_idle_pct;
  int recv_idle_pct;
  int holdoff_left;
  int mismatch_count;
  int requests_sent;
  int ticks_sent;
  int fires_checked;
  int quiet_cycles;

  timing_wheel_timer_scheduler_core #(
    .SLOTS  (SLOTS),
    .TIMERS (TIMERS)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .mode      (mode),
    .timer_id  (timer_id),
    .period    (period),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .fired_id  (fired_id),
    .last      (last)
  );

  // Clock with a 20 ns period.
  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Arm one predicted timer from the current slot, clamping a zero period to one.
  function automatic void arm_timer_model(input int idx, input logic [PERIOD_W-1:0] p);
    logic [PERIOD_W-1:0] q;
    q = (p == '0) ? PERIOD_W'(1) : p;
    period_m[idx] = q;
    slot_m[idx]   = 4'((int'(cur_slot_m) + int'(q)) % SLOTS);
    rounds_m[idx] = PERIOD_W'((int'(q) - 1) / SLOTS);
    armed_m[idx]  = 1'b1;
  endfunction

  // Update the predicted wheel for one accepted request and queue the fired ids it causes.
  task automatic predict_request(input logic [MODE_W-1:0] m, input logic [ID_W-1:0] id,
                                 input logic [PERIOD_W-1:0] p);
    logic   due [TIMERS];
    fired_t hits[$];
    fired_t hit;
    case (m)
      MODE_ADD: begin
        if (int'(id) < TIMERS) arm_timer_model(int'(id), p);
      end
      MODE_DELETE: begin
        if (int'(id) < TIMERS) armed_m[id] = 1'b0;
      end
      MODE_TICK: begin
        cur_slot_m = 4'((int'(cur_slot_m) + 1) % SLOTS);
        // Decide the whole slot first so a re-armed timer is not seen twice.
        for (int i = 0; i < TIMERS; i++) begin
          due[i] = 1'b0;
          if (armed_m[i] && slot_m[i] == cur_slot_m) begin
            if (rounds_m[i] == '0) due[i] = 1'b1;
            else rounds_m[i] = rounds_m[i] - 1'b1;
          end
        end
        for (int i = 0; i < TIMERS; i++) begin
          if (due[i]) begin
            arm_timer_model(i, period_m[i]);
            if (hits.size() < MAX_FIRED) begin
              hit.id   = ID_W'(i);
              hit.last = 1'b0;
              hits.insert(hits.size(), hit);
            end
          end
        end
        if (hits.size() > 0) hits[hits.size()-1].last = 1'b1;
        foreach (hits[k]) fired_expect_q.insert(fired_expect_q.size(), hits[k]);
      end
      default: begin
      end
    endcase
  endtask

  // Offer one request, with random idle cycles ahead of it, and wait until it is taken.
  task automatic send_request(input logic [MODE_W-1:0] m, input logic [ID_W-1:0] id,
                              input logic [PERIOD_W-1:0] p);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    mode     = m;
    timer_id = id;
    period   = p;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_request(m, id, p);
    requests_sent++;
    if (m == MODE_TICK) ticks_sent++;
  endtask

  // Random request: mostly ticks and adds with short periods, some deletes and unused modes.
  task automatic send_random_request();
    int                  pick;
    int                  span;
    logic [PERIOD_W-1:0] p;
    pick = $urandom_range(0, 99);
    span = $urandom_range(0, 9);
    if (span < 8) p = PERIOD_W'($urandom_range(0, 25));
    else if (span == 8) p = PERIOD_W'($urandom_range(26, 300));
    else p = PERIOD_W'($urandom);
    if (pick < 45) send_request(MODE_TICK, ID_W'($urandom), PERIOD_W'($urandom));
    else if (pick < 80) send_request(MODE_ADD, ID_W'($urandom), p);
    else if (pick < 95) send_request(MODE_DELETE, ID_W'($urandom), PERIOD_W'($urandom));
    else send_request(MODE_UNUSED, ID_W'($urandom), PERIOD_W'($urandom));
  endtask

  // Wait until every predicted result has come out.
  task automatic wait_for_drain();
    while (fired_expect_q.size() != 0) @(posedge clk);
  endtask

  // A period of one fires every tick; two timers due together come out in id order.
  task automatic test_single_fire();
    send_request(MODE_ADD, 4'd0, 16'd1);
    send_request(MODE_TICK, 4'd0, 16'd0);
    send_request(MODE_ADD, 4'd15, 16'd0);
    send_request(MODE_TICK, 4'd15, 16'hFFFF);
  endtask

  // Re-arm of an armed timer, delete, delete of an unarmed timer and the unused mode.
  task automatic test_rearm_and_delete();
    send_request(MODE_ADD, 4'd15, 16'hFFFF);
    send_request(MODE_DELETE, 4'd0, 16'h0000);
    send_request(MODE_TICK, 4'd0, 16'h0000);
    send_request(MODE_DELETE, 4'd0, 16'hFFFF);
    send_request(MODE_UNUSED, 4'd15, 16'hFFFF);
  endtask

  // Periods of a whole wheel turn and past it, including a re-arm into the current slot.
  task automatic test_period_multiples();
    send_request(MODE_ADD, 4'd7, 16'd10);
    send_request(MODE_ADD, 4'd8, 16'd20);
    send_request(MODE_ADD, 4'd9, 16'd11);
    repeat (11) send_request(MODE_TICK, 4'd0, 16'd0);
  endtask

  // Random requests under one idling pattern.
  task automatic test_random_phase(input int count, input int snd_pct, input int rcv_pct);
    send_idle_pct = snd_pct;
    recv_idle_pct = rcv_pct;
    repeat (count) send_random_request();
  endtask

  // The receiver holds off for a long stretch while ticks keep coming, so the core fills up.
  task automatic test_output_holdoff();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    for (int i = 1; i <= 4; i++) send_request(MODE_ADD, ID_W'(i), 16'd1);
    @(posedge clk);
    holdoff_left = HOLDOFF_LEN;
    repeat (12) send_request(MODE_TICK, 4'd0, 16'd0);
  endtask

  // Receiver side: random stall, or a forced stall during a hold-off.
  always @(negedge clk) begin
    if (holdoff_left > 0) begin
      out_stall = 1'b1;
      holdoff_left--;
    end else begin
      out_stall = ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  // Compare each accepted result with the oldest predicted one.
  always @(posedge clk) begin
    fired_t want;
    if (!rst && out_valid && !out_stall) begin
      fires_checked++;
      if (fired_expect_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("%0t: unexpected result fired_id %0d last %0d", $realtime, fired_id, last);
      end else begin
        want = fired_expect_q.pop_front();
        if (fired_id !== want.id || last !== want.last) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("%0t: mismatch fired_id expected %0d got %0d, last expected %0d got %0d",
                     $realtime, want.id, fired_id, want.last, last);
        end
      end
    end
  end

  // Watchdog: end the run when nothing moves on either channel for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Watchdog: no request or result moved for %0d cycles", STALL_LIMIT);
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  initial begin
    rst            = 1'b1;
    in_valid       = 1'b0;
    mode           = MODE_TICK;
    timer_id       = '0;
    period         = '0;
    out_stall      = 1'b0;
    send_idle_pct  = 0;
    recv_idle_pct  = 0;
    holdoff_left   = 0;
    mismatch_count = 0;
    requests_sent  = 0;
    ticks_sent     = 0;
    fires_checked  = 0;
    quiet_cycles   = 0;
    cur_slot_m     = '0;
    for (int i = 0; i < TIMERS; i++) begin
      armed_m[i]  = 1'b0;
      period_m[i] = '0;
      slot_m[i]   = '0;
      rounds_m[i] = '0;
    end
    repeat (4) @(negedge clk);
    rst = 1'b0;

    test_single_fire();
    test_rearm_and_delete();
    test_period_multiples();
    test_random_phase(65, 7, 81);
    test_random_phase(65, 81, 7);
    test_output_holdoff();
    test_random_phase(65, 0, 0);

    @(negedge clk);
    in_valid = 1'b0;
    wait_for_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d requests (%0d ticks) and checked %0d fired timers.",
             requests_sent, ticks_sent, fires_checked);
    $display("Covered adds, deletes, unused mode, zero and full-range periods, output hold-off.");
    if (mismatch_count == 0 && fired_expect_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      if (fired_expect_q.size() != 0)
        $display("%0d predicted results never came out", fired_expect_q.size());
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
